>>> rtl/core/tlzw_pkg.sv
// Package with the shared types, constants and codes of the TIFF LZW strip decoder.
package tlzw_pkg;

  // Field widths fixed by the item format.
  localparam int CFG_W    = 24;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // Bit unpacker sizes.
  localparam int BUF_W      = 20;
  localparam int HELD_W     = 5;
  localparam int CW_W       = 4;
  localparam int HELD_LIMIT = 12;

  // Default configuration of the string table and code widths.
  localparam int TABLE_DEPTH   = 4096;
  localparam int MIN_CODE_BITS = 9;
  localparam int MAX_CODE_BITS = 12;

  // Queue depths on both sides of the decoder core.
  localparam int OP_QUEUE_DEPTH  = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Reserved LZW codes.
  localparam int ROOT_COUNT = 256;
  localparam int CLEAR_CODE = 256;
  localparam int EOI_CODE   = 257;
  localparam int FIRST_FREE = 258;

  // Command codes of an input request.
  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_PULL  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Status codes of a result request.
  typedef enum logic [STATUS_W-1:0] {
    ST_BYTE = 3'd0,
    ST_NEED = 3'd1,
    ST_DONE = 3'd2,
    ST_ERR  = 3'd3,
    ST_ACC  = 3'd4
  } status_t;

  // Strip decoding phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  // Decoder core sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_CODE,
    B_WALK,
    B_LINK,
    B_POP,
    B_OUT
  } bstate_t;

  // Input request as it arrives on the ports.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] in_byte;
  } in_item_t;

  // Result request as it leaves on the ports.
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Classified request handed from the front to the decoder core.
  typedef struct packed {
    cmd_t              kind;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

>>> rtl/core/tiff_lzw_decoder.sv
// Top level of the TIFF LZW strip decoder: front queue, decoder core, result queue.
// Flow: a start, push or idle command goes from the core's idle state to its output state,
// and a pull of a stacked byte passes the pop state between them. A pull that must decode
// first runs code steps (including the step that finds too few bits), a walk step for the root
// and a walk and a link step per chained entry. The core holds one request at a time.
// Reset (rst_n low, synchronous): queues empty, phase idle, strip size register zero.
module tiff_lzw_decoder #(
  parameter int TABLE_DEPTH   = tlzw_pkg::TABLE_DEPTH,
  parameter int MIN_CODE_BITS = tlzw_pkg::MIN_CODE_BITS,
  parameter int MAX_CODE_BITS = tlzw_pkg::MAX_CODE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  tlzw_pkg::in_item_t         in_item,
  output logic                       empty,
  input  logic                       pop,
  output tlzw_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [tlzw_pkg::CFG_W-1:0] cfg_wdata
);

  logic [tlzw_pkg::CFG_W-1:0] strip_bytes_r;
  logic                       op_valid, op_pop;
  tlzw_pkg::op_t              op;
  logic                       res_full, res_push;
  tlzw_pkg::out_item_t        res;

  // Strip size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_bytes_r <= '0;
    end else if (cfg_we) begin
      strip_bytes_r <= cfg_wdata;
    end
  end

  tlzw_front #(
    .DEPTH (tlzw_pkg::OP_QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op_pop   (op_pop),
    .op       (op)
  );

  tlzw_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MIN_CODE_BITS (MIN_CODE_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .strip_bytes (strip_bytes_r),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  tlzw_fifo #(
    .W     ($bits(tlzw_pkg::out_item_t)),
    .DEPTH (tlzw_pkg::RES_QUEUE_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

>>> rtl/core/tlzw_fifo.sv
// Small synchronous queue used on both sides of the decoder core.
module tlzw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/tlzw_front.sv
// Front part: accepts input requests, classifies the command and queues them for the core.
module tlzw_front #(
  parameter int DEPTH = tlzw_pkg::OP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tlzw_pkg::in_item_t in_item,
  output logic               op_valid,
  input  logic               op_pop,
  output tlzw_pkg::op_t      op
);

  tlzw_pkg::op_t op_in;
  logic          op_empty;

  // Classify the raw command into the core's request kind.
  always_comb begin
    case (in_item.cmd)
      tlzw_pkg::CMD_START: op_in.kind = tlzw_pkg::CMD_START;
      tlzw_pkg::CMD_PUSH:  op_in.kind = tlzw_pkg::CMD_PUSH;
      tlzw_pkg::CMD_PULL:  op_in.kind = tlzw_pkg::CMD_PULL;
      default:             op_in.kind = tlzw_pkg::CMD_NOP;
    endcase
    op_in.data = in_item.in_byte;
  end

  tlzw_fifo #(
    .W     ($bits(tlzw_pkg::op_t)),
    .DEPTH (DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (op_in),
    .full    (full),
    .rd_en   (op_pop),
    .rd_data (op),
    .empty   (op_empty)
  );

  assign op_valid = !op_empty;

endmodule

>>> rtl/core/tlzw_back.sv
// Back part: bit unpacker, string table, unwind stack and strip sequencer.
module tlzw_back #(
  parameter int TABLE_DEPTH   = tlzw_pkg::TABLE_DEPTH,
  parameter int MIN_CODE_BITS = tlzw_pkg::MIN_CODE_BITS,
  parameter int MAX_CODE_BITS = tlzw_pkg::MAX_CODE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tlzw_pkg::CFG_W-1:0] strip_bytes,
  input  logic                       op_valid,
  input  tlzw_pkg::op_t              op,
  output logic                       op_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output tlzw_pkg::out_item_t        res
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int FREE_W = IDX_W + 1;
  localparam int CMP_W  = (FREE_W > MAX_CODE_BITS + 1) ? FREE_W : MAX_CODE_BITS + 1;
  localparam int BYTE_W = tlzw_pkg::BYTE_W;
  localparam int ENT_W  = IDX_W + BYTE_W;
  localparam int BUF_W  = tlzw_pkg::BUF_W;
  localparam int HELD_W = tlzw_pkg::HELD_W;
  localparam int CW_W   = tlzw_pkg::CW_W;
  localparam int CFG_W  = tlzw_pkg::CFG_W;

  tlzw_pkg::bstate_t state_r, state_nxt;
  tlzw_pkg::phase_t  phase_r, phase_nxt;

  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [CW_W-1:0]   cw_r, cw_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic              prev_none_r, prev_none_nxt;
  logic              prev_clr_r, prev_clr_nxt;
  logic [BYTE_W-1:0] prev_first_r, prev_first_nxt;
  logic [FREE_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              add_pend_r, add_pend_nxt;
  logic [IDX_W-1:0]  add_idx_r, add_idx_nxt;
  logic [IDX_W-1:0]  add_link_r, add_link_nxt;
  tlzw_pkg::out_item_t res_r, res_nxt;
  logic              res_stk_r, res_stk_nxt;

  // String table (link and suffix of entries) and unwind stack.
  logic [ENT_W-1:0]  ent_mem [TABLE_DEPTH];
  logic [ENT_W-1:0]  ent_rd_r;
  logic              ent_we;
  logic [IDX_W-1:0]  ent_wa;
  logic [ENT_W-1:0]  ent_wd;
  logic [BYTE_W-1:0] stk_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0] stk_rd_r;
  logic              stk_we, stk_re;
  logic [IDX_W-1:0]  stk_wa, stk_ra;
  logic [BYTE_W-1:0] stk_wd;

  // Code extraction helpers.
  logic              code_ok;
  logic [HELD_W-1:0] rem;
  logic [BUF_W-1:0]  shifted, cmask, buf_left;
  logic [CMP_W-1:0]  code_c, free_c, free_inc, thr;
  logic              k_root;
  logic [FREE_W-1:0] cnt_dec;
  logic [CFG_W-1:0]  left_dec;

  // Next code sits MSB-first in the top bits of those still held.
  always_comb begin
    code_ok  = (HELD_W'(cw_r) <= held_r);
    rem      = held_r - HELD_W'(cw_r);
    shifted  = buf_r >> rem;
    cmask    = (BUF_W'(1) << cw_r) - BUF_W'(1);
    code_c   = CMP_W'(shifted & cmask);
    buf_left = buf_r & ((BUF_W'(1) << rem) - BUF_W'(1));
    free_c   = CMP_W'(free_r);
    free_inc = free_c + CMP_W'(1);
    thr      = (CMP_W'(1) << cw_r) - CMP_W'(2);
    k_root   = (k_r < IDX_W'(tlzw_pkg::ROOT_COUNT));
    cnt_dec  = cnt_r - FREE_W'(1);
    left_dec = left_r - CFG_W'(1);
  end

  // Sequencer: next state, datapath updates and memory ports.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    buf_nxt        = buf_r;
    held_nxt       = held_r;
    cw_nxt         = cw_r;
    free_nxt       = free_r;
    prev_nxt       = prev_r;
    prev_none_nxt  = prev_none_r;
    prev_clr_nxt   = prev_clr_r;
    prev_first_nxt = prev_first_r;
    cnt_nxt        = cnt_r;
    left_nxt       = left_r;
    k_nxt          = k_r;
    add_pend_nxt   = add_pend_r;
    add_idx_nxt    = add_idx_r;
    add_link_nxt   = add_link_r;
    res_nxt        = res_r;
    res_stk_nxt    = res_stk_r;
    op_pop         = 1'b0;
    res_push       = 1'b0;
    ent_we         = 1'b0;
    ent_wa         = free_r[IDX_W-1:0];
    ent_wd         = {prev_r, prev_first_r};
    stk_we         = 1'b0;
    stk_wa         = cnt_r[IDX_W-1:0];
    stk_wd         = k_r[BYTE_W-1:0];
    stk_re         = 1'b0;
    stk_ra         = cnt_dec[IDX_W-1:0];

    case (state_r)
      // Take the next classified request from the front.
      tlzw_pkg::B_IDLE: begin
        if (op_valid) begin
          op_pop      = 1'b1;
          res_stk_nxt = 1'b0;
          res_nxt     = '{out_byte: '0, status: tlzw_pkg::ST_ACC};
          state_nxt   = tlzw_pkg::B_OUT;
          case (op.kind)
            tlzw_pkg::CMD_START: begin
              buf_nxt       = '0;
              held_nxt      = '0;
              cw_nxt        = CW_W'(MIN_CODE_BITS);
              free_nxt      = FREE_W'(tlzw_pkg::FIRST_FREE);
              prev_none_nxt = 1'b1;
              prev_clr_nxt  = 1'b0;
              cnt_nxt       = '0;
              add_pend_nxt  = 1'b0;
              left_nxt      = strip_bytes;
              phase_nxt     = (strip_bytes != '0) ? tlzw_pkg::PH_RUN : tlzw_pkg::PH_DONE;
            end
            tlzw_pkg::CMD_PUSH: begin
              if (phase_r == tlzw_pkg::PH_ERR) begin
                res_nxt.status = tlzw_pkg::ST_ERR;
              end else if (phase_r == tlzw_pkg::PH_RUN) begin
                if (held_r > HELD_W'(tlzw_pkg::HELD_LIMIT)) begin
                  res_nxt.status = tlzw_pkg::ST_ERR;
                end else begin
                  buf_nxt  = {buf_r[BUF_W-BYTE_W-1:0], op.data};
                  held_nxt = held_r + HELD_W'(BYTE_W);
                end
              end
            end
            tlzw_pkg::CMD_PULL: begin
              if (phase_r == tlzw_pkg::PH_ERR) begin
                res_nxt.status = tlzw_pkg::ST_ERR;
              end else if (phase_r != tlzw_pkg::PH_RUN) begin
                res_nxt.status = tlzw_pkg::ST_DONE;
              end else if (cnt_r != '0) begin
                state_nxt = tlzw_pkg::B_POP;
              end else begin
                state_nxt = tlzw_pkg::B_CODE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Unpack and act on one code per cycle until a string is ready, bits run short or an error is found.
      tlzw_pkg::B_CODE: begin
        if (!code_ok) begin
          res_nxt.status = tlzw_pkg::ST_NEED;
          state_nxt      = tlzw_pkg::B_OUT;
        end else begin
          held_nxt = rem;
          buf_nxt  = buf_left;
          if (code_c == CMP_W'(tlzw_pkg::CLEAR_CODE)) begin
            free_nxt      = FREE_W'(tlzw_pkg::FIRST_FREE);
            cw_nxt        = CW_W'(MIN_CODE_BITS);
            prev_clr_nxt  = 1'b1;
            prev_none_nxt = 1'b0;
          end else if (code_c == CMP_W'(tlzw_pkg::EOI_CODE) || prev_none_r ||
                       (prev_clr_r && code_c >= CMP_W'(tlzw_pkg::FIRST_FREE)) ||
                       (!prev_clr_r && (code_c > free_c ||
                                        free_c >= CMP_W'(TABLE_DEPTH)))) begin
            phase_nxt      = tlzw_pkg::PH_ERR;
            cnt_nxt        = '0;
            res_nxt.status = tlzw_pkg::ST_ERR;
            state_nxt      = tlzw_pkg::B_OUT;
          end else if (prev_clr_r) begin
            // First code after a clear is a root: nothing is added.
            prev_clr_nxt = 1'b0;
            prev_nxt     = code_c[IDX_W-1:0];
            k_nxt        = code_c[IDX_W-1:0];
            add_pend_nxt = 1'b0;
            state_nxt    = tlzw_pkg::B_WALK;
          end else begin
            // The repeated-string case writes its entry now so the walk can read it;
            // otherwise the suffix is the first byte found at the end of the walk.
            if (code_c == free_c) begin
              ent_we       = 1'b1;
              add_pend_nxt = 1'b0;
            end else begin
              add_pend_nxt = 1'b1;
              add_idx_nxt  = free_r[IDX_W-1:0];
              add_link_nxt = prev_r;
            end
            free_nxt = FREE_W'(free_inc);
            if (free_inc > thr && cw_r < CW_W'(MAX_CODE_BITS)) begin
              cw_nxt = cw_r + CW_W'(1);
            end
            prev_nxt  = code_c[IDX_W-1:0];
            k_nxt     = code_c[IDX_W-1:0];
            state_nxt = tlzw_pkg::B_WALK;
          end
        end
      end

      // Walk the chain; a root ends it and gives the first byte.
      tlzw_pkg::B_WALK: begin
        if (k_root) begin
          stk_we         = 1'b1;
          cnt_nxt        = cnt_r + FREE_W'(1);
          prev_first_nxt = k_r[BYTE_W-1:0];
          if (add_pend_r) begin
            ent_we = 1'b1;
            ent_wa = add_idx_r;
            ent_wd = {add_link_r, k_r[BYTE_W-1:0]};
          end
          add_pend_nxt = 1'b0;
          state_nxt    = tlzw_pkg::B_POP;
        end else begin
          state_nxt = tlzw_pkg::B_LINK;
        end
      end

      // Table data has arrived: stack the suffix and follow the link.
      tlzw_pkg::B_LINK: begin
        stk_we    = 1'b1;
        stk_wd    = ent_rd_r[BYTE_W-1:0];
        cnt_nxt   = cnt_r + FREE_W'(1);
        k_nxt     = ent_rd_r[ENT_W-1:BYTE_W];
        state_nxt = tlzw_pkg::B_WALK;
      end

      // Pop the top of the stack and count the byte against the strip size.
      tlzw_pkg::B_POP: begin
        stk_re         = 1'b1;
        cnt_nxt        = cnt_dec;
        left_nxt       = left_dec;
        res_stk_nxt    = 1'b1;
        res_nxt.status = tlzw_pkg::ST_BYTE;
        if (left_dec == '0) begin
          phase_nxt = tlzw_pkg::PH_DONE;
          cnt_nxt   = '0;
        end
        state_nxt = tlzw_pkg::B_OUT;
      end

      // Hand the result to the result queue.
      tlzw_pkg::B_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = tlzw_pkg::B_IDLE;
        end
      end

      default: begin
        state_nxt = tlzw_pkg::B_IDLE;
      end
    endcase
  end

  assign res.status   = res_r.status;
  assign res.out_byte = res_stk_r ? stk_rd_r : res_r.out_byte;

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlzw_pkg::B_IDLE;
      phase_r      <= tlzw_pkg::PH_IDLE;
      buf_r        <= '0;
      held_r       <= '0;
      cw_r         <= CW_W'(MIN_CODE_BITS);
      free_r       <= FREE_W'(tlzw_pkg::FIRST_FREE);
      prev_none_r  <= 1'b1;
      prev_clr_r   <= 1'b0;
      cnt_r        <= '0;
      left_r       <= '0;
      add_pend_r   <= 1'b0;
      res_stk_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      buf_r        <= buf_nxt;
      held_r       <= held_nxt;
      cw_r         <= cw_nxt;
      free_r       <= free_nxt;
      prev_none_r  <= prev_none_nxt;
      prev_clr_r   <= prev_clr_nxt;
      cnt_r        <= cnt_nxt;
      left_r       <= left_nxt;
      add_pend_r   <= add_pend_nxt;
      res_stk_r    <= res_stk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    prev_first_r <= prev_first_nxt;
    k_r          <= k_nxt;
    add_idx_r    <= add_idx_nxt;
    add_link_r   <= add_link_nxt;
    res_r        <= res_nxt;
  end

  // String table: one write port, one registered read at the walk pointer.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_r <= ent_mem[k_r];
  end

  // Unwind stack: one write port, one registered read for pops.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

endmodule

>>> rtl/core/tlzw_checker.sv
// Port-level checker for the TIFF LZW strip decoder and its bind.
module tlzw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input tlzw_pkg::out_item_t out_item
);

  // The result queue comes out of reset empty and the front queue not full.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // Every result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status == tlzw_pkg::ST_BYTE || out_item.status == tlzw_pkg::ST_NEED ||
                out_item.status == tlzw_pkg::ST_DONE || out_item.status == tlzw_pkg::ST_ERR ||
                out_item.status == tlzw_pkg::ST_ACC))
    else $error("undefined result status");

  // Only a byte result carries a nonzero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != tlzw_pkg::ST_BYTE) |-> (out_item.out_byte == '0))
    else $error("nonzero byte on a status-only result");

  // A waiting result that is not taken stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule

bind tiff_lzw_decoder tlzw_checker u_tlzw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
